// File: src/perfect_number_test_macros.svh
// ----------------------------------------------------------------------------
// perfect number test assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PERFECT_NUMBER_TEST_MACROS_SVH
`define PERFECT_NUMBER_TEST_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PNT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pnt assertion failed");

// next-cycle implication
`define PNT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pnt assertion failed");

`else

`define PNT_ASSERT_NOW(lbl, ante, cons)

`define PNT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: src/pnt_pkg.sv
// ----------------------------------------------------------------------------
// pnt_pkg
// widths and shared types of the perfect number test
// ----------------------------------------------------------------------------
package pnt_pkg;

	localparam int NUM_WIDTH = 32;
	localparam int IN_WIDTH  = 32;
	localparam int CNT_W     = $clog2(NUM_WIDTH);

	typedef logic [NUM_WIDTH-1:0] num_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic done;
		num_t quo;
		num_t rem;
	} div_res_t;

endpackage

// File: src/pnt_div.sv
// ----------------------------------------------------------------------------
// pnt_div
// restoring divider, one quotient bit per cycle between go and done
// ----------------------------------------------------------------------------
module pnt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  pnt_pkg::num_t     dividend,
	input  pnt_pkg::num_t     divisor,
	output pnt_pkg::div_res_t res
);
	import pnt_pkg::*;

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	num_t             quo_q;
	num_t             rem_q;

	logic [NUM_WIDTH:0] shifted;
	logic [NUM_WIDTH:0] diff;
	logic               fits;

	assign shifted = {rem_q, quo_q[NUM_WIDTH-1]};
	assign diff    = shifted - {1'b0, divisor};
	assign fits    = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_WIDTH - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[NUM_WIDTH-2:0], fits};
			rem_q <= fits ? diff[NUM_WIDTH-1:0] : shifted[NUM_WIDTH-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quo  = quo_q;
	assign res.rem  = rem_q;

endmodule

// File: src/perfect_number_test.sv
// ----------------------------------------------------------------------------
// perfect_number_test
// trial-division perfect number check over one shared serial divider
// ----------------------------------------------------------------------------
// usage:
//   drive number and pulse start while busy is low; the transaction is
//   taken at that clock edge; for numbers of two or more busy rises on the
//   next cycle. done is high for exactly one cycle, answer on perfect;
//   the receiver cannot stall, so it must take the result in that cycle.
// sequence:
//   numbers below two raise done straight from idle with perfect low.
//   otherwise each trial divisor d, from two upward, takes one divide of
//   the number plus an add step when d divides it; the search stops once
//   the quotient falls below d, or early once the divisor sum passes n.
// throughput:
//   one item at a time; busy stays high until the result strobe.
// reset:
//   arst_n clears the sequencer and divider control; no item is in flight
//   and no result is pending after reset.
// ----------------------------------------------------------------------------
`include "perfect_number_test_macros.svh"

module perfect_number_test (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [pnt_pkg::IN_WIDTH-1:0]  number,
	output logic                          done,
	output logic                          perfect
);
	import pnt_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_ADD  = 2'd2;

	logic [1:0]       state_q;
	logic             go_q;
	logic             done_q;
	logic             perfect_q;
	num_t             n_q;
	num_t             d_q;
	num_t             acc_q;
	logic [NUM_WIDTH:0] add_q;

	num_t     n_in;
	num_t     room;
	div_res_t res;

	assign n_in = NUM_WIDTH'(number);
	assign room = n_q - acc_q;

	pnt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go_q),
		.dividend (n_q),
		.divisor  (d_q),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			go_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (n_in < NUM_WIDTH'(2)) begin
							done_q <= 1'b1;
						end else begin
							go_q    <= 1'b1;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (res.done) begin
						if (res.quo < d_q) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (res.rem == '0) begin
							state_q <= S_ADD;
						end else begin
							go_q <= 1'b1;
						end
					end
				end
				S_ADD: begin
					if (add_q > {1'b0, room}) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						go_q    <= 1'b1;
						state_q <= S_DIV;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					n_q       <= n_in;
					d_q       <= NUM_WIDTH'(2);
					acc_q     <= NUM_WIDTH'(1);
					perfect_q <= 1'b0;
				end
			end
			S_DIV: begin
				if (res.done) begin
					if (res.quo < d_q) begin
						perfect_q <= (acc_q == n_q);
					end else if (res.rem == '0) begin
						// square-root divisor counts once
						add_q <= (res.quo == d_q) ? {1'b0, d_q}
							: {1'b0, d_q} + {1'b0, res.quo};
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
			end
			S_ADD: begin
				if (add_q > {1'b0, room}) begin
					perfect_q <= 1'b0;
				end else begin
					acc_q <= acc_q + add_q[NUM_WIDTH-1:0];
					d_q   <= d_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign perfect = perfect_q;

	`PNT_ASSERT_NOW(a_done_idle, done, !busy)
	`PNT_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done)
	`PNT_ASSERT_NOW(a_sum_bounded, busy, (acc_q <= n_q) && (d_q >= NUM_WIDTH'(2)))

endmodule
